### sv/trqs_pkg.sv
`default_nettype none

package trqs_pkg;

  localparam int TASK_W = 4;
  localparam int QID_W  = 3;
  localparam int MCNT_W = 5;
  localparam int STAT_W = 2;

  typedef enum logic [1:0] {
    REQ_SCHED       = 2'd0,
    REQ_BLOCK       = 2'd1,
    REQ_UNBLOCK_ONE = 2'd2,
    REQ_UNBLOCK_ALL = 2'd3
  } req_t;

  localparam logic [STAT_W-1:0] STAT_OK          = 2'd0;
  localparam logic [STAT_W-1:0] STAT_READY_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_WAIT_EMPTY  = 2'd2;

  typedef struct packed {
    req_t             req;
    logic [QID_W-1:0] queue_id;
  } cmd_t;

  typedef struct packed {
    logic [TASK_W-1:0] running_task;
    logic              running_valid;
    logic [TASK_W-1:0] moved_task;
    logic [MCNT_W-1:0] moved_count;
    logic [STAT_W-1:0] status;
  } result_t;

endpackage

`default_nettype wire

### sv/trqs_ifs.sv
`default_nettype none

interface trqs_in_if import trqs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [QID_W-1:0] queue_id;
  modport source (output valid, req_type, queue_id, input ready);
  modport sink (input valid, req_type, queue_id, output ready);
endinterface

interface trqs_out_if import trqs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TASK_W-1:0] running_task;
  logic              running_valid;
  logic [TASK_W-1:0] moved_task;
  logic [MCNT_W-1:0] moved_count;
  logic [STAT_W-1:0] status;
  modport source (output valid, running_task, running_valid, moved_task, moved_count,
                  status, input ready);
  modport sink (input valid, running_task, running_valid, moved_task, moved_count,
                status, output ready);
endinterface

interface trqs_cfg_if import trqs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TASK_W-1:0] idle_task;
  modport source (output valid, idle_task, input ready);
  modport sink (input valid, idle_task, output ready);
endinterface

`default_nettype wire

### sv/trqs_front.sv
`default_nettype none

module trqs_front import trqs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  trqs_in_if.sink   in_chan,
  output logic      cmd_valid,
  output cmd_t      cmd,
  input  wire logic cmd_pop
);

  // Two-entry command queue between the request port and the sequencer.
  cmd_t       cmd_q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       cmd_in;

  assign in_chan.ready = (cnt_r != 2'd2);
  assign push          = in_chan.valid && in_chan.ready;

  always_comb begin
    cmd_in.req      = req_t'(in_chan.req_type);
    cmd_in.queue_id = in_chan.queue_id;
  end

  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = cmd_q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/trqs_back.sv
`default_nettype none

module trqs_back import trqs_pkg::*; #(
  parameter int NUM_TASKS       = 16,
  parameter int NUM_WAIT_QUEUES = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [TASK_W-1:0] idle_task,
  input  wire logic              cmd_valid,
  input  wire cmd_t              cmd,
  output logic                   cmd_pop,
  output logic                   out_valid,
  output result_t                result,
  input  wire logic              out_ready
);

  localparam int IW  = $clog2(NUM_TASKS);
  localparam int CW  = $clog2(NUM_TASKS + 1);
  localparam int SW  = CW + 1;
  localparam int QW  = (NUM_WAIT_QUEUES > 1) ? $clog2(NUM_WAIT_QUEUES) : 1;
  localparam int WAW = $clog2(NUM_WAIT_QUEUES * NUM_TASKS);
  localparam int XW  = IW + CW;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_SCHED = 5'b00100,
    S_UNB   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(NUM_TASKS)) sum = sum - SW'(NUM_TASKS);
    return IW'(sum);
  endfunction

  function automatic logic [WAW-1:0] waddr(input logic [QW-1:0] q, input logic [IW-1:0] pos);
    return WAW'(int'(q) * NUM_TASKS + int'(pos));
  endfunction

  state_t            state_r, state_nxt;
  req_t              req_r, req_nxt;
  logic [QW-1:0]     q_r, q_nxt;
  logic [TASK_W-1:0] cur_task_r, cur_task_nxt;
  logic              cur_valid_r, cur_valid_nxt;
  logic              cur_blk_r, cur_blk_nxt;
  logic [IW-1:0]     rhead_r, rhead_nxt;
  logic [CW-1:0]     rcnt_r, rcnt_nxt;
  logic [IW-1:0]     whead_r, whead_nxt;
  logic [CW-1:0]     wcnt_r, wcnt_nxt;
  logic [TASK_W-1:0] mtask_r, mtask_nxt;
  logic [CW-1:0]     mcnt_r, mcnt_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_r, out_nxt;

  // Ready FIFO store, wait FIFO stores, and per-queue head/count words.
  logic [TASK_W-1:0] ready_mem [NUM_TASKS];
  logic [TASK_W-1:0] wait_mem [NUM_WAIT_QUEUES * NUM_TASKS];
  logic [XW-1:0]     ctl_mem [NUM_WAIT_QUEUES];
  logic [NUM_WAIT_QUEUES-1:0] ctl_vld_r;
  logic [TASK_W-1:0] ready_rd_r;
  logic [TASK_W-1:0] wait_rd_r;
  logic [XW-1:0]     ctl_rd_r;
  logic              ctl_rv_r;

  logic              ready_we;
  logic [IW-1:0]     ready_wa;
  logic [TASK_W-1:0] ready_wd;
  logic              wait_we;
  logic [WAW-1:0]    wait_wa;
  logic [TASK_W-1:0] wait_wd;
  logic [WAW-1:0]    wait_ra;
  logic              ctl_we;
  logic [XW-1:0]     ctl_wd;
  logic [QW-1:0]     ctl_ra;

  logic [QW-1:0]     q_cmd;
  logic [XW-1:0]     ctl_word;
  logic [IW-1:0]     c_head;
  logic [CW-1:0]     c_cnt;
  logic [IW-1:0]     h1;
  logic [CW-1:0]     c1;

  assign q_cmd    = QW'(int'(cmd.queue_id) % NUM_WAIT_QUEUES);
  assign ctl_word = ctl_rv_r ? ctl_rd_r : '0;
  assign c_head   = ctl_word[XW-1:CW];
  assign c_cnt    = ctl_word[CW-1:0];
  assign h1       = wrap_add(whead_r, CW'(1));
  assign c1       = wcnt_r - CW'(1);
  assign ctl_ra   = (state_r == S_IDLE) ? q_cmd : q_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    q_nxt         = q_r;
    cur_task_nxt  = cur_task_r;
    cur_valid_nxt = cur_valid_r;
    cur_blk_nxt   = cur_blk_r;
    rhead_nxt     = rhead_r;
    rcnt_nxt      = rcnt_r;
    whead_nxt     = whead_r;
    wcnt_nxt      = wcnt_r;
    mtask_nxt     = mtask_r;
    mcnt_nxt      = mcnt_r;
    stat_nxt      = stat_r;
    out_nxt       = out_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    cmd_pop       = 1'b0;
    ready_we      = 1'b0;
    ready_wa      = wrap_add(rhead_r, rcnt_r);
    ready_wd      = cur_task_r;
    wait_we       = 1'b0;
    wait_wa       = waddr(q_r, wrap_add(c_head, c_cnt));
    wait_wd       = cur_task_r;
    wait_ra       = waddr(q_r, whead_r);
    ctl_we        = 1'b0;
    ctl_wd        = {h1, c1};

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          req_nxt   = cmd.req;
          q_nxt     = q_cmd;
          mcnt_nxt  = '0;
          mtask_nxt = '0;
          stat_nxt  = STAT_OK;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        case (req_r)
          REQ_SCHED: begin
            state_nxt = S_SCHED;
          end
          REQ_BLOCK: begin
            if (!cur_blk_r) begin
              cur_blk_nxt = 1'b1;
              if (c_cnt < CW'(NUM_TASKS)) begin
                wait_we = 1'b1;
                ctl_we  = 1'b1;
                ctl_wd  = {c_head, c_cnt + CW'(1)};
              end
            end
            state_nxt = S_SCHED;
          end
          default: begin
            if (c_cnt == '0) begin
              stat_nxt  = STAT_WAIT_EMPTY;
              state_nxt = S_DONE;
            end else begin
              whead_nxt = c_head;
              wcnt_nxt  = c_cnt;
              wait_ra   = waddr(q_r, c_head);
              state_nxt = S_UNB;
            end
          end
        endcase
      end
      S_SCHED: begin
        if (rcnt_r == '0) begin
          stat_nxt = STAT_READY_EMPTY;
          if (cur_blk_r) cur_valid_nxt = 1'b0;
        end else begin
          rhead_nxt = wrap_add(rhead_r, CW'(1));
          if (cur_valid_r && !cur_blk_r && (cur_task_r != idle_task)) begin
            // The old task lands behind the popped head, so the count holds.
            ready_we = 1'b1;
          end else begin
            rcnt_nxt = rcnt_r - CW'(1);
          end
          cur_task_nxt  = ready_rd_r;
          cur_valid_nxt = 1'b1;
          cur_blk_nxt   = 1'b0;
        end
        state_nxt = S_DONE;
      end
      S_UNB: begin
        if (mcnt_r == '0) mtask_nxt = wait_rd_r;
        mcnt_nxt = mcnt_r + CW'(1);
        if ((int'(wait_rd_r) % NUM_TASKS) == (int'(cur_task_r) % NUM_TASKS)) begin
          cur_blk_nxt = 1'b0;
        end
        if (rcnt_r < CW'(NUM_TASKS)) begin
          ready_we = 1'b1;
          ready_wd = wait_rd_r;
          rcnt_nxt = rcnt_r + CW'(1);
        end
        whead_nxt = h1;
        wcnt_nxt  = c1;
        if ((req_r == REQ_UNBLOCK_ONE) || (c1 == '0)) begin
          ctl_we    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          wait_ra = waddr(q_r, h1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.running_task  = cur_task_r;
          out_nxt.running_valid = cur_valid_r;
          out_nxt.moved_task    = mtask_r;
          out_nxt.moved_count   = MCNT_W'(mcnt_r);
          out_nxt.status        = stat_r;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ready_we) ready_mem[ready_wa] <= ready_wd;
    ready_rd_r <= ready_mem[rhead_r];
    if (wait_we) wait_mem[wait_wa] <= wait_wd;
    wait_rd_r <= wait_mem[wait_ra];
    if (ctl_we) ctl_mem[q_r] <= ctl_wd;
    ctl_rd_r <= ctl_mem[ctl_ra];
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    q_r     <= q_nxt;
    whead_r <= whead_nxt;
    wcnt_r  <= wcnt_nxt;
    mtask_r <= mtask_nxt;
    mcnt_r  <= mcnt_nxt;
    stat_r  <= stat_nxt;
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_task_r  <= '0;
      cur_valid_r <= 1'b0;
      cur_blk_r   <= 1'b0;
      rhead_r     <= '0;
      rcnt_r      <= '0;
      out_valid_r <= 1'b0;
      ctl_vld_r   <= '0;
      ctl_rv_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_task_r  <= cur_task_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_blk_r   <= cur_blk_nxt;
      rhead_r     <= rhead_nxt;
      rcnt_r      <= rcnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (ctl_we) ctl_vld_r[q_r] <= 1'b1;
      ctl_rv_r    <= ctl_vld_r[ctl_ra];
    end
  end

  assign out_valid = out_valid_r;
  assign result    = out_r;

endmodule

`default_nettype wire

### sv/task_ready_queue_scheduler_core.sv
`default_nettype none

// Hardware task scheduler with one ready FIFO and NUM_WAIT_QUEUES wait FIFOs of
// task ids. Each request transaction on in_chan (schedule, block current,
// unblock one, unblock all) yields exactly one result transaction on out_chan
// with the running task, the first task moved and the number moved, and a
// status that flags an empty ready FIFO or an empty wait FIFO. A front stage
// queues up to two requests, so requests are taken while a result waits.
// The back sequencer handles one request at a time, and its steps are set by
// the registered reads of the FIFO memories. After a request is accepted, a
// load step uses the queue's head/count word; schedule and block then take a
// scheduling step, unblock one and unblock all take a move step for each task
// moved, and an unblock on an empty wait queue goes straight to the result
// step. A result that is not taken holds the sequencer in its last step until
// the result register frees up. The idle task id is written on cfg_chan
// (reset value 1); the user must write it only while the block is idle, which
// the block itself does not enforce. A preempted idle task is not put back on
// the ready FIFO. No clearing pass is needed after reset.
module task_ready_queue_scheduler_core import trqs_pkg::*; #(
  parameter int NUM_TASKS       = 16,
  parameter int NUM_WAIT_QUEUES = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  trqs_in_if.sink    in_chan,
  trqs_out_if.source out_chan,
  trqs_cfg_if.sink   cfg_chan
);

  // Configuration register: the idle task id.
  logic [TASK_W-1:0] idle_r, idle_nxt;

  logic    cmd_valid;
  cmd_t    cmd;
  logic    cmd_pop;
  result_t result;

  assign cfg_chan.ready = 1'b1;
  assign idle_nxt = (cfg_chan.valid && cfg_chan.ready) ? cfg_chan.idle_task : idle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r <= TASK_W'(1);
    end else begin
      idle_r <= idle_nxt;
    end
  end

  // The front stage accepts and classifies request transactions.
  trqs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // The back sequencer owns all queue state and the result register.
  trqs_back #(
    .NUM_TASKS       (NUM_TASKS),
    .NUM_WAIT_QUEUES (NUM_WAIT_QUEUES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .idle_task (idle_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_chan.valid),
    .result    (result),
    .out_ready (out_chan.ready)
  );

  assign out_chan.running_task  = result.running_task;
  assign out_chan.running_valid = result.running_valid;
  assign out_chan.moved_task    = result.moved_task;
  assign out_chan.moved_count   = result.moved_count;
  assign out_chan.status        = result.status;

endmodule

`default_nettype wire

### sv/trqs_checker.sv
`default_nettype none

module trqs_checker import trqs_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [TASK_W-1:0] out_moved_task,
  input wire logic [MCNT_W-1:0] out_moved_count,
  input wire logic [STAT_W-1:0] out_status
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_moved_count))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK) || (out_status == STAT_READY_EMPTY) ||
    (out_status == STAT_WAIT_EMPTY))
    else $error("status code out of range");

  a_err_nomove: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> (out_moved_count == '0) &&
    (out_moved_task == '0))
    else $error("tasks moved on a failed request");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind task_ready_queue_scheduler_core trqs_checker u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_moved_task  (out_chan.moved_task),
  .out_moved_count (out_chan.moved_count),
  .out_status      (out_chan.status)
);

`default_nettype wire

### dv/tb_task_ready_queue_scheduler_core.sv
`timescale 1ns / 100ps

module tb_task_ready_queue_scheduler_core;
  import trqs_pkg::*;

  localparam int NTASK = 16;
  localparam int NWQ = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 3;
  localparam int PHASE_ITEMS = 250;

  localparam logic [1:0] TS_READY = 2'd0;
  localparam logic [1:0] TS_RUNNING = 2'd1;
  localparam logic [1:0] TS_BLOCKED = 2'd2;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #4 clk = ~clk;

  trqs_in_if in_chan ();
  trqs_out_if out_chan ();
  trqs_cfg_if cfg_chan ();

  task_ready_queue_scheduler_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  // Predictor state.
  logic [3:0] m_idle;
  logic [3:0] m_cur;
  logic       m_cval;
  logic [1:0] m_state [NTASK];
  logic [3:0] m_ready [NTASK];
  int         m_rhead;
  int         m_rcnt;
  logic [3:0] m_wait [NWQ][NTASK];
  int         m_whead [NWQ];
  int         m_wcnt [NWQ];

  cmd_t    pend_q[$];
  result_t exp_q[$];
  result_t pred;
  result_t got;
  result_t want;
  cmd_t    cur_item;

  int n_queued = 0;
  int n_acc = 0;
  int n_issued = 0;
  int n_recv = 0;
  int n_err = 0;
  int cyc = 0;
  int burst_left = 0;
  int gap_left = 0;
  int rcv_cyc = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  task automatic report_mismatch(input string what);
    n_err++;
    $display("mismatch %0d at cycle %0d: %s", n_err, cyc, what);
  endtask

  task automatic m_reset();
    m_idle = 4'd1;
    m_cur = 4'd0;
    m_cval = 1'b0;
    m_rhead = 0;
    m_rcnt = 0;
    for (int i = 0; i < NTASK; i++) begin
      m_state[i] = TS_READY;
      m_ready[i] = 4'd0;
    end
    for (int q = 0; q < NWQ; q++) begin
      m_whead[q] = 0;
      m_wcnt[q] = 0;
      for (int i = 0; i < NTASK; i++) begin
        m_wait[q][i] = 4'd0;
      end
    end
  endtask

  task automatic m_ready_push(input logic [3:0] id);
    if (m_rcnt < NTASK) begin
      m_ready[(m_rhead + m_rcnt) % NTASK] = id;
      m_rcnt++;
    end
  endtask

  task automatic m_ready_pop(output logic [3:0] id);
    id = m_ready[m_rhead];
    m_rhead = (m_rhead + 1) % NTASK;
    m_rcnt--;
  endtask

  task automatic m_wait_push(input int q, input logic [3:0] id);
    if (m_wcnt[q] < NTASK) begin
      m_wait[q][(m_whead[q] + m_wcnt[q]) % NTASK] = id;
      m_wcnt[q]++;
    end
  endtask

  task automatic m_wait_pop(input int q, output logic [3:0] id);
    id = m_wait[q][m_whead[q]];
    m_whead[q] = (m_whead[q] + 1) % NTASK;
    m_wcnt[q]--;
  endtask

  task automatic m_schedule(output logic [1:0] st);
    logic [3:0] nxt;
    int         old;
    old = int'(m_cur) % NTASK;
    if (m_rcnt == 0) begin
      if (m_state[old] == TS_BLOCKED) m_cval = 1'b0;
      st = STAT_READY_EMPTY;
    end else begin
      m_ready_pop(nxt);
      if (m_cval && (m_state[old] != TS_BLOCKED)) begin
        m_state[old] = TS_READY;
        if (m_cur != m_idle) m_ready_push(m_cur);
      end
      m_cur = nxt;
      m_cval = 1'b1;
      m_state[int'(nxt) % NTASK] = TS_RUNNING;
      st = STAT_OK;
    end
  endtask

  task automatic m_unblock_head(input int q, output logic [3:0] id);
    m_wait_pop(q, id);
    m_state[int'(id) % NTASK] = TS_READY;
    m_ready_push(id);
  endtask

  task automatic m_step(input req_t req, input logic [QID_W-1:0] qid, output result_t r);
    int         q;
    int         s;
    int         mc;
    logic [1:0] st;
    logic [3:0] mt;
    logic [3:0] tmp;
    q = int'(qid) % NWQ;
    st = STAT_OK;
    mt = 4'd0;
    mc = 0;
    case (req)
      REQ_SCHED: begin
        m_schedule(st);
      end
      REQ_BLOCK: begin
        s = int'(m_cur) % NTASK;
        if (m_state[s] != TS_BLOCKED) begin
          m_state[s] = TS_BLOCKED;
          m_wait_push(q, m_cur);
        end
        m_schedule(st);
      end
      default: begin
        if (m_wcnt[q] == 0) begin
          st = STAT_WAIT_EMPTY;
        end else if (req == REQ_UNBLOCK_ONE) begin
          m_unblock_head(q, mt);
          mc = 1;
        end else begin
          m_unblock_head(q, mt);
          mc = 1;
          while (m_wcnt[q] != 0) begin
            m_unblock_head(q, tmp);
            mc++;
          end
        end
      end
    endcase
    r.running_task  = m_cur;
    r.running_valid = m_cval;
    r.moved_task    = mt;
    r.moved_count   = MCNT_W'(mc);
    r.status        = st;
  endtask

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cyc++;
    if (cyc >= CYCLE_LIMIT) begin
      report_mismatch("cycle limit reached");
      $display("** task_ready_queue_scheduler_core: FAILED **");
      $finish;
    end
  end

  // Predictor: follows configuration writes and accepted request transactions.
  always @(posedge clk) begin
    if (!rst_n) begin
      m_reset();
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) m_idle = cfg_chan.idle_task;
      if (in_chan.valid && in_chan.ready) begin
        m_step(req_t'(in_chan.req_type), in_chan.queue_id, pred);
        exp_q.push_back(pred);
        n_acc++;
      end
    end
  end

  // Driver: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid    <= 1'b0;
      in_chan.req_type <= 2'd0;
      in_chan.queue_id <= '0;
    end else if (!in_chan.valid || (n_acc == n_issued)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_chan.valid <= 1'b0;
      end else if (pend_q.size() == 0) begin
        in_chan.valid <= 1'b0;
      end else begin
        cur_item = pend_q.pop_front();
        in_chan.valid    <= 1'b1;
        in_chan.req_type <= cur_item.req;
        in_chan.queue_id <= cur_item.queue_id;
        n_issued++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = int'($urandom_range(1, 12));
          gap_left   = int'($urandom_range(0, 6));
        end
      end
    end
  end

  // One long hold-off of the receiver while the sender keeps offering.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!hold_done && (n_recv >= 40)) begin
        hold_left = 90;
        hold_done = 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
      end
    end
  end

  // Receiver: stalls on a fixed pattern and during the long hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      rcv_cyc++;
      out_chan.ready <= (hold_left == 0) && ((rcv_cyc % 11) < 8);
    end
  end

  // Monitor: compares every result transaction with the prediction.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.running_task  = out_chan.running_task;
      got.running_valid = out_chan.running_valid;
      got.moved_task    = out_chan.moved_task;
      got.moved_count   = out_chan.moved_count;
      got.status        = out_chan.status;
      if (exp_q.size() == 0) begin
        report_mismatch("result without a pending request");
      end else begin
        want = exp_q.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf(
            "result %0d: exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d", n_recv,
            want.running_task, want.running_valid, want.moved_task, want.moved_count,
            want.status, got.running_task, got.running_valid, got.moved_task,
            got.moved_count, got.status));
        end
      end
      n_recv++;
    end
  end

  initial begin
    cmd_t       c;
    logic [3:0] v;
    cfg_chan.valid     = 1'b0;
    cfg_chan.idle_task = 4'd0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        // Change the idle task only once every transaction has completed.
        wait (n_recv == n_queued);
        v = (ph == 1) ? 4'd0 : 4'($urandom_range(0, 15));
        @(negedge clk);
        cfg_chan.idle_task = v;
        cfg_chan.valid     = 1'b1;
        do @(posedge clk); while (!cfg_chan.ready);
        @(negedge clk);
        cfg_chan.valid = 1'b0;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: c.req = REQ_SCHED;
          3, 4, 5: c.req = REQ_BLOCK;
          6, 7, 8: c.req = REQ_UNBLOCK_ONE;
          default: c.req = REQ_UNBLOCK_ALL;
        endcase
        if ($urandom_range(0, 3) == 0) begin
          c.queue_id = QID_W'($urandom_range(0, 7));
        end else begin
          c.queue_id = QID_W'($urandom_range(0, 1));
        end
        pend_q.push_back(c);
        n_queued++;
      end
    end
    wait (n_recv == n_queued);
    repeat (10) @(posedge clk);
    if ((n_err == 0) && (exp_q.size() == 0)) begin
      $display("** task_ready_queue_scheduler_core: PASSED **");
    end else begin
      $display("** task_ready_queue_scheduler_core: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
sv/trqs_pkg.sv
sv/trqs_ifs.sv
sv/trqs_front.sv
sv/trqs_back.sv
sv/task_ready_queue_scheduler_core.sv
sv/trqs_checker.sv
dv/tb_task_ready_queue_scheduler_core.sv
